// ----- rtl/mts_pkg.sv -----
package mts_pkg;

    // Field widths of the request and response beats.
    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 7;

    // Default number of entries the stack holds.
    localparam int DEFAULT_STACK_DEPTH = 64;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [DEPTH_W-1:0]        t_depth;

    // Top and minimum read as the largest positive value on an empty stack.
    localparam t_value INT_MAX = 32'sh7FFF_FFFF;

    // Request codes; the unused code behaves as a query.
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    // Response status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } t_state;

    // Enables from the sequencer to the entry memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

// ----- rtl/mts_req_if.sv -----
interface mts_req_if;

    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic signed [mts_pkg::VALUE_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

// ----- rtl/mts_rsp_if.sv -----
interface mts_rsp_if;

    logic                  valid;
    logic                  ready;
    logic signed [mts_pkg::VALUE_W-1:0] top_value;
    logic signed [mts_pkg::VALUE_W-1:0] min_value;
    logic [mts_pkg::DEPTH_W-1:0]        depth;
    logic [1:0]            status;

    modport source (output valid, output top_value, output min_value, output depth,
                    output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input depth,
                    input status, output ready);

endinterface

// ----- rtl/mts_ram.sv -----
module mts_ram #(
    parameter int DEPTH  = mts_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 2 * mts_pkg::VALUE_W
) (
    input  logic              i_clk,
    input  mts_pkg::t_ram_ctl i_ctl,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Single read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/min_tracking_stack.sv -----
// Channel  Direction  Beat contents
// i_req    in         req_type, push_value
// o_rsp    out        top_value, min_value, depth, status
//
// The top entry and its running minimum sit in registers; entries below it
// live in one memory holding value and minimum side by side.
// Push, query and any refused request respond when taken. A pop that leaves the
// stack non-empty first reads the new top from the memory in the LOAD state.
// Reset empties the stack at once; the memory needs no clearing.
// A response waits in the output register; a new request is taken only once it drains.
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_req_if.sink   i_req,
    mts_rsp_if.source o_rsp
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DATA_W = 2 * mts_pkg::VALUE_W;

    mts_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    mts_pkg::t_value   r_top, n_top;
    mts_pkg::t_value   r_min, n_min;

    logic              r_out_valid;
    mts_pkg::t_value   r_out_top, n_out_top;
    mts_pkg::t_value   r_out_min, n_out_min;
    mts_pkg::t_depth   r_out_depth, n_out_depth;
    mts_pkg::t_status  r_out_status, n_out_status;
    logic              w_out_load;

    logic              w_accept;
    mts_pkg::t_req     w_req;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_cnt_m2;
    mts_pkg::t_ram_ctl w_ram_ctl;
    logic [DATA_W-1:0] w_rd_data;

    // Entries below the top.
    mts_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_ram_ctl),
        .i_wr_addr (w_cnt_m1[ADDR_W-1:0]),
        .i_wr_data ({r_top, r_min}),
        .i_rd_addr (w_cnt_m2[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Requests are taken when idle and the output register is free or draining.
    assign i_req.ready = (r_state == mts_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_req       = mts_pkg::t_req'(i_req.req_type);
    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_cnt_m2    = r_count - CNT_W'(2);

    // Request sequencing and response formation.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_min        = r_min;
        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;
        w_out_load   = 1'b0;
        w_ram_ctl    = '0;

        case (r_state)
            mts_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_out_load   = 1'b1;
                    n_out_top    = r_top;
                    n_out_min    = r_min;
                    n_out_depth  = mts_pkg::t_depth'(r_count);
                    n_out_status = mts_pkg::STAT_OK;
                    case (w_req)
                        mts_pkg::REQ_PUSH: begin
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_out_status = mts_pkg::STAT_FULL;
                            end else begin
                                // The old top moves down into the memory.
                                w_ram_ctl.wr_en = (r_count != '0);
                                n_top           = i_req.push_value;
                                if (r_count == '0 || i_req.push_value < r_min) begin
                                    n_min = i_req.push_value;
                                end
                                n_count     = r_count + CNT_W'(1);
                                n_out_top   = n_top;
                                n_out_min   = n_min;
                                n_out_depth = mts_pkg::t_depth'(n_count);
                            end
                        end
                        mts_pkg::REQ_POP: begin
                            if (r_count == '0) begin
                                n_out_status = mts_pkg::STAT_EMPTY;
                                n_out_top    = mts_pkg::INT_MAX;
                                n_out_min    = mts_pkg::INT_MAX;
                            end else if (r_count == CNT_W'(1)) begin
                                n_count     = '0;
                                n_out_top   = mts_pkg::INT_MAX;
                                n_out_min   = mts_pkg::INT_MAX;
                                n_out_depth = '0;
                            end else begin
                                // The new top must be fetched; the response is loaded in the LOAD state.
                                w_ram_ctl.rd_en = 1'b1;
                                w_out_load      = 1'b0;
                                n_count         = w_cnt_m1;
                                n_state         = mts_pkg::ST_LOAD;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out_status = mts_pkg::STAT_EMPTY;
                                n_out_top    = mts_pkg::INT_MAX;
                                n_out_min    = mts_pkg::INT_MAX;
                            end
                        end
                    endcase
                end
            end
            mts_pkg::ST_LOAD: begin
                n_top        = w_rd_data[DATA_W-1:mts_pkg::VALUE_W];
                n_min        = w_rd_data[mts_pkg::VALUE_W-1:0];
                w_out_load   = 1'b1;
                n_out_top    = n_top;
                n_out_min    = n_min;
                n_out_depth  = mts_pkg::t_depth'(r_count);
                n_out_status = mts_pkg::STAT_OK;
                n_state      = mts_pkg::ST_IDLE;
            end
            default: begin
                n_state = mts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mts_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Cached top entry and response payload.
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_min <= n_min;
        if (w_out_load) begin
            r_out_top    <= n_out_top;
            r_out_min    <= n_out_min;
            r_out_depth  <= n_out_depth;
            r_out_status <= n_out_status;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.top_value = r_out_top;
    assign o_rsp.min_value = r_out_min;
    assign o_rsp.depth     = r_out_depth;
    assign o_rsp.status    = r_out_status;

endmodule
